// ===== rtl/core/lps_pkg.sv =====
// Shared types and constants of the line pixel stepper.
package lps_pkg;

    localparam int FIELD_W    = 16;
    localparam int COLOR_W    = 16;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr above the byte offset.
    localparam logic REG_PEN_COLOR = 1'b0;

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_PLUS  = 2'd1;
    localparam logic [1:0] DIR_MINUS = 2'd3;

    typedef struct packed {
        logic [FIELD_W-1:0] pixel_x;
        logic [FIELD_W-1:0] pixel_y;
        logic [COLOR_W-1:0] pixel_color;
        logic               last_pixel;
    } pixel_t;

    typedef struct packed {
        logic valid;
        logic busy;
        logic last;
    } step_status_t;

endpackage

// ===== rtl/core/lps_in_if.sv =====
// Command channel: start a line or step one pixel.
interface lps_in_if;
    logic                        valid;
    logic                        ready;
    logic                        action;
    logic [lps_pkg::FIELD_W-1:0] x_start;
    logic [lps_pkg::FIELD_W-1:0] y_start;
    logic [lps_pkg::FIELD_W-1:0] x_end;
    logic [lps_pkg::FIELD_W-1:0] y_end;

    modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface

// ===== rtl/core/lps_out_if.sv =====
// Pixel channel: one rasterized pixel per item.
interface lps_out_if;
    logic                        valid;
    logic                        ready;
    logic [lps_pkg::FIELD_W-1:0] pixel_x;
    logic [lps_pkg::FIELD_W-1:0] pixel_y;
    logic [lps_pkg::COLOR_W-1:0] pixel_color;
    logic                        last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

// ===== rtl/core/lps_apb_regs.sv =====
// APB register block holding the pen color.
module lps_apb_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lps_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [lps_pkg::COLOR_W-1:0]    pen_color
);

    logic [lps_pkg::COLOR_W-1:0] pen_color_reg;
    logic                        reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_color_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_idx == lps_pkg::REG_PEN_COLOR)
        begin
            pen_color_reg <= pwdata[lps_pkg::COLOR_W-1:0];
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            lps_pkg::REG_PEN_COLOR: prdata = lps_pkg::APB_DATA_W'(pen_color_reg);
            default:                prdata = '0;
        endcase
    end

    assign pen_color = pen_color_reg;

endmodule

// ===== rtl/core/lps_stepper.sv =====
// Line state and the per-item setup and step arithmetic.
module lps_stepper #(
    parameter int COORD_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         action,
    input  logic [lps_pkg::FIELD_W-1:0]  x_start,
    input  logic [lps_pkg::FIELD_W-1:0]  y_start,
    input  logic [lps_pkg::FIELD_W-1:0]  x_end,
    input  logic [lps_pkg::FIELD_W-1:0]  y_end,
    input  logic [lps_pkg::COLOR_W-1:0]  pen_color,
    output lps_pkg::pixel_t              result,
    output lps_pkg::step_status_t        status
);

    localparam int ERR_W  = COORD_BITS + 2;
    localparam int LEFT_W = COORD_BITS + 1;

    logic [COORD_BITS-1:0] cur_col_reg, cur_col_next;
    logic [COORD_BITS-1:0] cur_row_reg, cur_row_next;
    logic [ERR_W-1:0]      err_col_reg, err_col_next;
    logic [ERR_W-1:0]      err_row_reg, err_row_next;
    logic [COORD_BITS-1:0] abs_dx_reg, abs_dx_next;
    logic [COORD_BITS-1:0] abs_dy_reg, abs_dy_next;
    logic [1:0]            dir_col_reg, dir_col_next;
    logic [1:0]            dir_row_reg, dir_row_next;
    logic [COORD_BITS-1:0] major_len_reg, major_len_next;
    logic [LEFT_W-1:0]     pixels_left_reg, pixels_left_next;
    logic                  busy_reg, busy_next;

    logic [COORD_BITS-1:0] xs, ys, xe, ye;
    logic [COORD_BITS-1:0] mag_x, mag_y;
    logic [1:0]            dir_x, dir_y;
    logic [ERR_W-1:0]      sum_col, sum_row, major_ext;
    logic                  do_step;

    function automatic logic [COORD_BITS-1:0] move_axis(
        input logic [COORD_BITS-1:0] pos,
        input logic [1:0]            dir
    );
        case (dir)
            lps_pkg::DIR_PLUS:  move_axis = pos + COORD_BITS'(1);
            lps_pkg::DIR_MINUS: move_axis = pos - COORD_BITS'(1);
            default:            move_axis = pos;
        endcase
    endfunction

    assign xs = x_start[COORD_BITS-1:0];
    assign ys = y_start[COORD_BITS-1:0];
    assign xe = x_end[COORD_BITS-1:0];
    assign ye = y_end[COORD_BITS-1:0];

    always_comb
    begin
        if (xe > xs)
        begin
            mag_x = xe - xs;
            dir_x = lps_pkg::DIR_PLUS;
        end
        else if (xe == xs)
        begin
            mag_x = '0;
            dir_x = lps_pkg::DIR_NONE;
        end
        else
        begin
            mag_x = xs - xe;
            dir_x = lps_pkg::DIR_MINUS;
        end

        if (ye > ys)
        begin
            mag_y = ye - ys;
            dir_y = lps_pkg::DIR_PLUS;
        end
        else if (ye == ys)
        begin
            mag_y = '0;
            dir_y = lps_pkg::DIR_NONE;
        end
        else
        begin
            mag_y = ys - ye;
            dir_y = lps_pkg::DIR_MINUS;
        end
    end

    assign do_step   = accept && action == lps_pkg::ACT_STEP && busy_reg;
    assign major_ext = ERR_W'(major_len_reg);
    assign sum_col   = err_col_reg + ERR_W'(abs_dx_reg);
    assign sum_row   = err_row_reg + ERR_W'(abs_dy_reg);

    always_comb
    begin
        cur_col_next     = cur_col_reg;
        cur_row_next     = cur_row_reg;
        err_col_next     = err_col_reg;
        err_row_next     = err_row_reg;
        abs_dx_next      = abs_dx_reg;
        abs_dy_next      = abs_dy_reg;
        dir_col_next     = dir_col_reg;
        dir_row_next     = dir_row_reg;
        major_len_next   = major_len_reg;
        pixels_left_next = pixels_left_reg;
        busy_next        = busy_reg;

        if (accept && action == lps_pkg::ACT_START)
        begin
            abs_dx_next      = mag_x;
            abs_dy_next      = mag_y;
            dir_col_next     = dir_x;
            dir_row_next     = dir_y;
            major_len_next   = (mag_x > mag_y) ? mag_x : mag_y;
            cur_col_next     = xs;
            cur_row_next     = ys;
            err_col_next     = '0;
            err_row_next     = '0;
            pixels_left_next = LEFT_W'(major_len_next) + LEFT_W'(2);
            busy_next        = 1'b1;
        end
        else if (do_step)
        begin
            err_col_next = sum_col;
            err_row_next = sum_row;
            if (sum_col > major_ext)
            begin
                err_col_next = sum_col - major_ext;
                cur_col_next = move_axis(cur_col_reg, dir_col_reg);
            end
            if (sum_row > major_ext)
            begin
                err_row_next = sum_row - major_ext;
                cur_row_next = move_axis(cur_row_reg, dir_row_reg);
            end
            pixels_left_next = pixels_left_reg - LEFT_W'(1);
            busy_next        = pixels_left_next != '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg     <= '0;
            cur_row_reg     <= '0;
            err_col_reg     <= '0;
            err_row_reg     <= '0;
            abs_dx_reg      <= '0;
            abs_dy_reg      <= '0;
            dir_col_reg     <= lps_pkg::DIR_NONE;
            dir_row_reg     <= lps_pkg::DIR_NONE;
            major_len_reg   <= '0;
            pixels_left_reg <= '0;
            busy_reg        <= 1'b0;
        end
        else
        begin
            cur_col_reg     <= cur_col_next;
            cur_row_reg     <= cur_row_next;
            err_col_reg     <= err_col_next;
            err_row_reg     <= err_row_next;
            abs_dx_reg      <= abs_dx_next;
            abs_dy_reg      <= abs_dy_next;
            dir_col_reg     <= dir_col_next;
            dir_row_reg     <= dir_row_next;
            major_len_reg   <= major_len_next;
            pixels_left_reg <= pixels_left_next;
            busy_reg        <= busy_next;
        end
    end

    // The pixel shown is the position before this step moves it.
    assign result.pixel_x     = lps_pkg::FIELD_W'(cur_col_reg);
    assign result.pixel_y     = lps_pkg::FIELD_W'(cur_row_reg);
    assign result.pixel_color = pen_color;
    assign result.last_pixel  = pixels_left_reg == LEFT_W'(1);

    assign status.valid = do_step;
    assign status.busy  = busy_reg;
    assign status.last  = result.last_pixel;

endmodule

// ===== rtl/core/lps_skid.sv =====
// Two-entry output register with skid stage for the pixel channel.
module lps_skid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lps_pkg::pixel_t push_data,
    output logic            can_accept,
    lps_out_if.source       pix
);

    lps_pkg::pixel_t out_data_reg;
    lps_pkg::pixel_t skid_data_reg;
    logic            out_valid_reg;
    logic            skid_valid_reg;
    logic            pop;

    assign pop        = out_valid_reg && pix.ready;
    assign can_accept = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (push)
        begin
            if (out_valid_reg && !pop)
            begin
                skid_data_reg <= push_data;
            end
            else
            begin
                out_data_reg <= push_data;
            end
        end
    end

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = out_data_reg.pixel_x;
    assign pix.pixel_y     = out_data_reg.pixel_y;
    assign pix.pixel_color = out_data_reg.pixel_color;
    assign pix.last_pixel  = out_data_reg.last_pixel;

endmodule

// ===== rtl/core/line_pixel_stepper.sv =====
// Line rasterizer: start and step commands in, one pixel per step out.
//
// The cmd channel takes items: action 0 starts a line from (x_start,y_start)
// to (x_end,y_end) and gives no pixel; action 1 steps the line and gives one
// pixel on the pix channel. A line gives its longer axis delta plus two
// pixels, the first pixel twice, and flags the final one with last_pixel.
// A step with no line in progress gives nothing; a start drops any line in
// progress. The pen color comes from the APB register at offset 0.
// The stepper state is updated as each item is accepted, and the item's pixel
// is registered into the output register, or into the skid stage while the
// output register is held; one item can be accepted every cycle while the
// skid stage is not full.
// When the receiver stalls, one more pixel is held in a skid stage, and
// cmd.ready drops only while that stage is full.
// Reset clears the line state (idle), the pen color and the output stages.
module line_pixel_stepper #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lps_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lps_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    lps_in_if.sink                         cmd,
    lps_out_if.source                      pix
);

    logic [lps_pkg::COLOR_W-1:0] pen_color;
    logic                        cmd_accept;
    logic                        can_accept;
    lps_pkg::pixel_t             result;
    lps_pkg::step_status_t       status;

    assign cmd.ready  = can_accept;
    assign cmd_accept = cmd.valid && cmd.ready;

    lps_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .pen_color (pen_color)
    );

    lps_stepper #(
        .COORD_BITS (COORD_BITS)
    ) u_stepper (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (cmd_accept),
        .action    (cmd.action),
        .x_start   (cmd.x_start),
        .y_start   (cmd.y_start),
        .x_end     (cmd.x_end),
        .y_end     (cmd.y_end),
        .pen_color (pen_color),
        .result    (result),
        .status    (status)
    );

    lps_skid u_skid (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (status.valid),
        .push_data  (result),
        .can_accept (can_accept),
        .pix        (pix)
    );

    // A full skid stage always sits behind a valid output register.
    a_stall_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.ready |-> pix.valid)
        else $error("cmd.ready low without a pixel in the output register");

    // The final pixel of a line ends the line.
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        status.valid && status.last |=> !status.busy)
        else $error("line still busy after its final pixel");

    // An accepted start always leaves a line in progress.
    a_start_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_accept && cmd.action == lps_pkg::ACT_START |=> status.busy)
        else $error("start item did not open a line");

    // A step on an idle stepper produces no pixel.
    a_idle_step_silent: assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> !status.valid)
        else $error("pixel produced while idle");

endmodule

// ===== test/lps_checker.sv =====
// Pixel checker: predicts the rasterized pixels from observed commands and compares them.
module lps_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lps_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lps_pkg::APB_DATA_W-1:0] pwdata,
    input  logic [lps_pkg::APB_DATA_W-1:0] prdata,
    input  logic                           pready,
    lps_in_if                              cmd,
    lps_out_if                             pix,
    output int                             fails,
    output int                             pending
);
    import lps_pkg::*;

    localparam int REG_SHIFT = 2;

    logic [COLOR_W-1:0] pen_now;
    logic [FIELD_W-1:0] at_col;
    logic [FIELD_W-1:0] at_row;
    logic [FIELD_W-1:0] span_col;
    logic [FIELD_W-1:0] span_row;
    logic [FIELD_W-1:0] long_span;
    logic [1:0]         step_col;
    logic [1:0]         step_row;
    logic [17:0]        run_col;
    logic [17:0]        run_row;
    logic [16:0]        pixels_to_go;
    logic               drawing;
    pixel_t             pixels_due[$];

    task automatic report(string what, int unsigned want, int unsigned got);
        $display("%0t: mismatch in %s: expected %0h, got %0h", $realtime, what, want, got);
        fails++;
    endtask

    function automatic void measure_axis(input logic [FIELD_W-1:0] from,
                                         input logic [FIELD_W-1:0] to,
                                         output logic [FIELD_W-1:0] len,
                                         output logic [1:0] dir);
        if (to > from) begin
            len = to - from;
            dir = DIR_PLUS;
        end else if (to == from) begin
            len = '0;
            dir = DIR_NONE;
        end else begin
            len = from - to;
            dir = DIR_MINUS;
        end
    endfunction

    function automatic logic [FIELD_W-1:0] nudge(logic [FIELD_W-1:0] pos, logic [1:0] dir);
        case (dir)
            DIR_PLUS:  return pos + 1'b1;
            DIR_MINUS: return pos - 1'b1;
            default:   return pos;
        endcase
    endfunction

    // Applies one accepted command to the line state and queues the pixel it gives.
    task automatic rasterize_command();
        pixel_t due;
        int     sum;
        if (cmd.action == ACT_START) begin
            measure_axis(cmd.x_start, cmd.x_end, span_col, step_col);
            measure_axis(cmd.y_start, cmd.y_end, span_row, step_row);
            long_span    = (span_col > span_row) ? span_col : span_row;
            at_col       = cmd.x_start;
            at_row       = cmd.y_start;
            run_col      = '0;
            run_row      = '0;
            pixels_to_go = {1'b0, long_span} + 17'd2;
            drawing      = 1'b1;
        end else if (drawing) begin
            due.pixel_x     = at_col;
            due.pixel_y     = at_row;
            due.pixel_color = pen_now;
            due.last_pixel  = (pixels_to_go == 17'd1);
            pixels_due.push_back(due);
            sum = run_col + span_col;
            if (sum > long_span) begin
                sum    = sum - long_span;
                at_col = nudge(at_col, step_col);
            end
            run_col = sum[17:0];
            sum = run_row + span_row;
            if (sum > long_span) begin
                sum    = sum - long_span;
                at_row = nudge(at_row, step_row);
            end
            run_row = sum[17:0];
            pixels_to_go = pixels_to_go - 1'b1;
            if (pixels_to_go == '0)
                drawing = 1'b0;
        end
    endtask

    task automatic match_pixel();
        pixel_t due;
        if (pixels_due.size() == 0) begin
            report("pixel with none due", 0, pix.pixel_x);
        end else begin
            due = pixels_due.pop_front();
            if (pix.pixel_x !== due.pixel_x)
                report("pixel_x", due.pixel_x, pix.pixel_x);
            if (pix.pixel_y !== due.pixel_y)
                report("pixel_y", due.pixel_y, pix.pixel_y);
            if (pix.pixel_color !== due.pixel_color)
                report("pixel_color", due.pixel_color, pix.pixel_color);
            if (pix.last_pixel !== due.last_pixel)
                report("last_pixel", due.last_pixel, pix.last_pixel);
        end
    endtask

    initial begin
        fails   = 0;
        pending = 0;
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            pen_now      = '0;
            at_col       = '0;
            at_row       = '0;
            span_col     = '0;
            span_row     = '0;
            long_span    = '0;
            step_col     = DIR_NONE;
            step_row     = DIR_NONE;
            run_col      = '0;
            run_row      = '0;
            pixels_to_go = '0;
            drawing      = 1'b0;
            pixels_due.delete();
            pending      = 0;
        end else begin
            if (psel && penable && pready && paddr[APB_ADDR_W-1:REG_SHIFT] == REG_PEN_COLOR)
            begin
                if (pwrite)
                    pen_now = pwdata[COLOR_W-1:0];
                else if (prdata[COLOR_W-1:0] !== pen_now)
                    report("pen_color readback", pen_now, prdata[COLOR_W-1:0]);
            end
            // Commands first, so a pixel could never overtake its own prediction.
            if (cmd.valid && cmd.ready)
                rasterize_command();
            if (pix.valid && pix.ready)
                match_pixel();
            pending = pixels_due.size();
        end
    end
endmodule

// ===== test/testbench.sv =====
// Top of the line pixel stepper testbench: clock, reset, command and register stimulus, verdict.
module testbench;
    import lps_pkg::*;

    localparam logic [APB_ADDR_W-1:0] ADDR_PEN_COLOR = {REG_PEN_COLOR, 2'b00};
    localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED    = 3'd4;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int PHASE_ITEMS    = 480;

    logic clk = 1'b0;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic pready;
    int   fail_count;
    int   due_count;
    int   items_sent;
    bit   tx_calm;
    bit   squeeze_now;
    bit   squeezed;

    lps_in_if  cmd_ch ();
    lps_out_if pix_ch ();

    line_pixel_stepper u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .pix     (pix_ch)
    );

    lps_checker u_chk (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_ch),
        .pix     (pix_ch),
        .fails   (fail_count),
        .pending (due_count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

    // Mostly short gaps, a few long ones, none at all in a calm stretch.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [FIELD_W-1:0] offset_coord(logic [FIELD_W-1:0] from, int reach);
        int d;
        int t;
        d = $urandom_range(0, reach);
        t = $urandom_range(0, 1) ? int'(from) + d : int'(from) - d;
        if (t < 0)
            t = 0;
        if (t > 65535)
            t = 65535;
        return t[FIELD_W-1:0];
    endfunction

    function automatic logic [FIELD_W-1:0] edge_or_any();
        if ($urandom_range(0, 9) != 0)
            return FIELD_W'($urandom);
        return $urandom_range(0, 1) ? FIELD_W'(16'hFFFF - $urandom_range(0, 3))
                                    : FIELD_W'($urandom_range(0, 3));
    endfunction

    function automatic int axis_len(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
        return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    task automatic send_cmd(logic act, logic [FIELD_W-1:0] xs, logic [FIELD_W-1:0] ys,
                            logic [FIELD_W-1:0] xe, logic [FIELD_W-1:0] ye);
        int gap;
        gap = pick_gap(tx_calm);
        if (gap > 0)
        begin
            @(negedge clk);
            cmd_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        cmd_ch.valid   <= 1'b1;
        cmd_ch.action  <= act;
        cmd_ch.x_start <= xs;
        cmd_ch.y_start <= ys;
        cmd_ch.x_end   <= xe;
        cmd_ch.y_end   <= ye;
        do @(posedge clk); while (cmd_ch.ready !== 1'b1);
        items_sent++;
    endtask

    task automatic step_pixel();
        send_cmd(ACT_STEP, FIELD_W'($urandom), FIELD_W'($urandom),
                 FIELD_W'($urandom), FIELD_W'($urandom));
    endtask

    task automatic start_line(logic [FIELD_W-1:0] xs, logic [FIELD_W-1:0] ys,
                              logic [FIELD_W-1:0] xe, logic [FIELD_W-1:0] ye);
        send_cmd(ACT_START, xs, ys, xe, ye);
    endtask

    task automatic draw_line(logic [FIELD_W-1:0] xs, logic [FIELD_W-1:0] ys,
                             logic [FIELD_W-1:0] xe, logic [FIELD_W-1:0] ye);
        int major;
        major = axis_len(xs, xe) > axis_len(ys, ye) ? axis_len(xs, xe) : axis_len(ys, ye);
        start_line(xs, ys, xe, ye);
        repeat (major + 2) step_pixel();
    endtask

    // The command channel goes quiet for the duration of a register access.
    task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits until every predicted pixel has left, plus a margin for the output stages.
    task automatic drain();
        @(negedge clk);
        cmd_ch.valid <= 1'b0;
        while (due_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_pen(logic [COLOR_W-1:0] color);
        drain();
        apb_access(1'b1, ADDR_PEN_COLOR, {{(APB_DATA_W - COLOR_W){1'b0}}, color});
        apb_access(1'b0, ADDR_PEN_COLOR, '0);
    endtask

    // A well-formed line with random content, sometimes cut short or overrun by idle steps.
    task automatic random_line();
        logic [FIELD_W-1:0] xs;
        logic [FIELD_W-1:0] ys;
        logic [FIELD_W-1:0] xe;
        logic [FIELD_W-1:0] ye;
        int reach;
        int major;
        int n;
        int r;
        r = $urandom_range(0, 99);
        reach = (r < 80) ? 12 : (r < 98) ? 200 : 1000;
        xs = edge_or_any();
        ys = edge_or_any();
        xe = offset_coord(xs, reach);
        ye = offset_coord(ys, reach);
        major = axis_len(xs, xe) > axis_len(ys, ye) ? axis_len(xs, xe) : axis_len(ys, ye);
        r = $urandom_range(0, 99);
        if (r < 12)
            n = $urandom_range(0, major + 1);
        else if (r < 22)
            n = major + 2 + $urandom_range(1, 3);
        else
            n = major + 2;
        start_line(xs, ys, xe, ye);
        repeat (n) step_pixel();
    endtask

    task automatic random_phase(int quota);
        int r;
        int stop_at;
        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            tx_calm = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 6)
                step_pixel();
            else if (r < 10)
            begin
                // Wide line from anywhere, abandoned early.
                start_line(FIELD_W'($urandom), FIELD_W'($urandom),
                           FIELD_W'($urandom), FIELD_W'($urandom));
                repeat ($urandom_range(0, 20)) step_pixel();
            end else
                random_line();
        end
    endtask

    initial
    begin : pixel_sink
        int gap;
        int quiet_left;
        bit calm;
        gap = 0;
        quiet_left = 0;
        calm = 1'b0;
        pix_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (quiet_left == 0)
            begin
                calm = ($urandom_range(0, 3) == 0);
                quiet_left = $urandom_range(50, 200);
            end
            quiet_left--;
            if (squeeze_now && !squeezed)
            begin
                // Long hold-off so the block fills up and stops taking commands.
                squeezed = 1'b1;
                pix_ch.ready <= 1'b0;
                repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
            end else if (gap > 0)
            begin
                pix_ch.ready <= 1'b0;
                gap--;
            end else
            begin
                pix_ch.ready <= 1'b1;
                gap = pick_gap(calm);
            end
        end
    end

    initial
    begin
        rst_n          <= 1'b0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        cmd_ch.valid   <= 1'b0;
        cmd_ch.action  <= ACT_STEP;
        cmd_ch.x_start <= '0;
        cmd_ch.y_start <= '0;
        cmd_ch.x_end   <= '0;
        cmd_ch.y_end   <= '0;
        items_sent  = 0;
        tx_calm     = 1'b0;
        squeeze_now = 1'b0;
        squeezed    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, first with the pen color still at its reset value.
        step_pixel();
        draw_line(16'd0, 16'd0, 16'd0, 16'd0);
        step_pixel();
        apb_access(1'b0, ADDR_PEN_COLOR, '0);
        set_pen(16'hFFFF);
        apb_access(1'b1, ADDR_UNUSED, $urandom);
        apb_access(1'b0, ADDR_PEN_COLOR, '0);
        // Full-range line in the minus direction, replaced part way by another.
        start_line(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        repeat (3) step_pixel();
        start_line(16'h0000, 16'h0000, 16'hFFFF, 16'h0001);
        repeat (3) step_pixel();
        draw_line(16'hFFFF, 16'h0000, 16'hFFFC, 16'h0002);
        draw_line(16'h0001, 16'hFFFE, 16'h0001, 16'hFFFF);
        step_pixel();

        set_pen(COLOR_W'($urandom));
        start_line(16'd100, 16'd200, 16'd500, 16'd350);
        squeeze_now = 1'b1;
        repeat (402) step_pixel();
        random_phase(PHASE_ITEMS - 400);
        set_pen(16'h0000);
        random_phase(PHASE_ITEMS);
        set_pen(16'hFFFF);
        random_phase(PHASE_ITEMS);
        set_pen(COLOR_W'($urandom));
        random_phase(PHASE_ITEMS);

        drain();
        repeat (10) @(negedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
